/* design/aidl_pkg.sv */
// Shared constants, types and coefficient table of the averaged IR distance linearizer.
`default_nettype none

package aidl_pkg;

    // Default configuration
    localparam int WINDOW_DEF         = 10;
    localparam int ADC_FULL_SCALE_DEF = 1024;

    // Field widths
    localparam int SAMPLE_W = 10;
    localparam int DIST_W   = 20;

    // Fixed-point layout
    localparam int FRAC_W   = 16;                 // Q16 fraction of volts and coefficients
    localparam int AVG_W    = 10;                 // window average never exceeds one sample
    localparam int AVG5_W   = AVG_W + 3;          // avg * 5
    localparam int NUM_W    = AVG5_W + FRAC_W;    // avg * 5 * 2^16
    localparam int VOLT_W   = 19;                 // unsigned Q3.16
    localparam int ACC_W    = 40;                 // Horner accumulator, signed Q16
    localparam int HALF_W   = ACC_W / 2;          // multiplier split point
    localparam int PROD_W   = ACC_W + HALF_W;     // full product width
    localparam int DIST_SH  = 8;                  // Q16 -> Q8
    localparam int COEF_N   = 7;
    localparam int COEF_IW  = 3;

    localparam logic [VOLT_W-1:0]        VOLT_MAX = {VOLT_W{1'b1}};
    localparam logic signed [DIST_W-1:0] DIST_MAX = {1'b0, {(DIST_W-1){1'b1}}};
    localparam logic signed [DIST_W-1:0] DIST_MIN = {1'b1, {(DIST_W-1){1'b0}}};

    // Status from the window store
    typedef struct packed {
        logic done;     // one-cycle pulse: request has been folded into the total
        logic emit;     // window was full, a distance follows
    } win_status_t;

    // Polynomial coefficients, Q10.16, highest power first
    function automatic logic signed [ACC_W-1:0] poly_coef(input logic [COEF_IW-1:0] idx);
        logic signed [ACC_W-1:0] c;
        case (idx)
            3'd0:    c =  40'sd81933;
            3'd1:    c = -40'sd1074528;
            3'd2:    c =  40'sd5569446;
            3'd3:    c = -40'sd14775747;
            3'd4:    c =  40'sd21679309;
            3'd5:    c = -40'sd17832346;
            3'd6:    c =  40'sd7911506;
            default: c =  '0;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

/* design/aidl_if.sv */
// Valid/ready channel interfaces for converter samples and distance results.
`default_nettype none

interface aidl_sample_if;
    logic                          valid;
    logic                          ready;
    logic [aidl_pkg::SAMPLE_W-1:0] adc_sample;

    modport source (output valid, output adc_sample, input ready);
    modport sink   (input valid, input adc_sample, output ready);
endinterface

interface aidl_distance_if;
    logic                               valid;
    logic                               ready;
    logic signed [aidl_pkg::DIST_W-1:0] distance;

    modport source (output valid, output distance, input ready);
    modport sink   (input valid, input distance, output ready);
endinterface

`default_nettype wire

/* design/aidl_window.sv */
// Sample window memory with running total: fill phase, then read-modify-write of the oldest slot.
`default_nettype none

module aidl_window #(
    parameter int WINDOW  = aidl_pkg::WINDOW_DEF,
    parameter int TOTAL_W = 14
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [aidl_pkg::SAMPLE_W-1:0] sample,
    output aidl_pkg::win_status_t         status,
    output logic [TOTAL_W-1:0]            total
);
    import aidl_pkg::*;

    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int FILL_W = $clog2(WINDOW + 1);

    localparam logic W_IDLE = 1'b0;
    localparam logic W_READ = 1'b1;

    logic                 state_reg, state_next;
    logic [FILL_W-1:0]    fill_reg, fill_next;
    logic [SLOT_W-1:0]    slot_reg, slot_next;
    logic [TOTAL_W-1:0]   total_reg, total_next;
    logic [SAMPLE_W-1:0]  sample_reg, sample_next;
    logic                 done_reg, done_next;
    logic                 emit_reg, emit_next;

    logic [SAMPLE_W-1:0]  mem [WINDOW];
    logic [SAMPLE_W-1:0]  rd_data_reg;
    logic                 rd_en;
    logic                 wr_en;
    logic [SLOT_W-1:0]    wr_addr;
    logic [SAMPLE_W-1:0]  wr_data;
    logic                 filling;

    assign filling = (fill_reg < FILL_W'(WINDOW));

    // Control and running total
    always_comb
    begin
        state_next  = state_reg;
        fill_next   = fill_reg;
        slot_next   = slot_reg;
        total_next  = total_reg;
        sample_next = sample_reg;
        done_next   = 1'b0;
        emit_next   = emit_reg;
        rd_en       = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = slot_reg;
        wr_data     = sample;
        case (state_reg)
            W_IDLE:
            begin
                if (start)
                begin
                    if (filling)
                    begin
                        // fill phase: store in order, no result
                        wr_en      = 1'b1;
                        wr_addr    = fill_reg[SLOT_W-1:0];
                        total_next = total_reg + TOTAL_W'(sample);
                        fill_next  = fill_reg + 1'b1;
                        done_next  = 1'b1;
                        emit_next  = 1'b0;
                    end
                    else
                    begin
                        // fetch the oldest sample; it comes back next cycle
                        rd_en       = 1'b1;
                        sample_next = sample;
                        state_next  = W_READ;
                    end
                end
            end
            W_READ:
            begin
                // only one request in flight, so read and write of a slot never overlap
                wr_en      = 1'b1;
                wr_addr    = slot_reg;
                wr_data    = sample_reg;
                total_next = total_reg - TOTAL_W'(rd_data_reg) + TOTAL_W'(sample_reg);
                slot_next  = (slot_reg == SLOT_W'(WINDOW - 1)) ? '0 : slot_reg + 1'b1;
                done_next  = 1'b1;
                emit_next  = 1'b1;
                state_next = W_IDLE;
            end
            default:
            begin
                state_next = W_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= W_IDLE;
            fill_reg  <= '0;
            slot_reg  <= '0;
            total_reg <= '0;
            done_reg  <= 1'b0;
            emit_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            slot_reg  <= slot_next;
            total_reg <= total_next;
            done_reg  <= done_next;
            emit_reg  <= emit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg <= sample_next;
    end

    // Window memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[slot_reg];
        end
    end

    assign status.done = done_reg;
    assign status.emit = emit_reg;
    assign total       = total_reg;

endmodule

`default_nettype wire

/* design/aidl_divider.sv */
// Constant-divisor scaling by reciprocal multiplication: window average, then volts in Q3.16.
`default_nettype none

module aidl_divider #(
    parameter int WINDOW         = aidl_pkg::WINDOW_DEF,
    parameter int ADC_FULL_SCALE = aidl_pkg::ADC_FULL_SCALE_DEF,
    parameter int TOTAL_W        = 14
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [TOTAL_W-1:0]          total,
    output logic                        done,
    output logic [aidl_pkg::VOLT_W-1:0] volts
);
    import aidl_pkg::*;

    // floor(n * k / d) == floor(n * m / 2^s) with m = ceil(k * 2^s / d),
    // exact while 2^s >= d * 2^(bits of n)
    localparam int              S_AVG  = TOTAL_W + $clog2(WINDOW);
    localparam longint unsigned M_AVG  = ((64'd1 << S_AVG) + WINDOW - 1) / WINDOW;
    localparam int              P1_W   = S_AVG + AVG_W;
    localparam longint unsigned VOLT_K = 64'd5 << FRAC_W;
    localparam int              S_VOLT = AVG_W + $clog2(ADC_FULL_SCALE);
    localparam longint unsigned M_VOLT = ((VOLT_K << S_VOLT) + ADC_FULL_SCALE - 1)
                                         / ADC_FULL_SCALE;
    localparam int              P2_W   = AVG_W + $clog2(M_VOLT + 1);
    localparam int              VR_W   = P2_W - S_VOLT;
    localparam int              CMP_W  = (VR_W > VOLT_W) ? VR_W : VOLT_W;

    logic              avg_vld_reg, avg_vld_next;
    logic              volt_vld_reg, volt_vld_next;
    logic              done_reg, done_next;
    logic [P1_W-1:0]   p_avg_reg, p_avg_next;
    logic [P2_W-1:0]   p_volt_reg, p_volt_next;
    logic [VOLT_W-1:0] volts_reg, volts_next;

    logic [AVG_W-1:0]  avg;
    logic [VR_W-1:0]   vraw;
    logic              vsat;

    assign avg  = p_avg_reg[P1_W-1:S_AVG];
    assign vraw = p_volt_reg[P2_W-1:S_VOLT];
    assign vsat = (CMP_W'(vraw) > CMP_W'(VOLT_MAX));

    // Three stages: average, volt scaling, clamp
    always_comb
    begin
        avg_vld_next  = start;
        volt_vld_next = avg_vld_reg;
        done_next     = volt_vld_reg;
        p_avg_next    = p_avg_reg;
        p_volt_next   = p_volt_reg;
        volts_next    = volts_reg;
        // total / WINDOW
        if (start)
        begin
            p_avg_next = P1_W'(total) * P1_W'(M_AVG);
        end
        // avg * 5 * 2^16 / ADC_FULL_SCALE
        if (avg_vld_reg)
        begin
            p_volt_next = P2_W'(avg) * P2_W'(M_VOLT);
        end
        // clamp to Q3.16
        if (volt_vld_reg)
        begin
            volts_next = vsat ? VOLT_MAX : VOLT_W'(vraw);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            avg_vld_reg  <= 1'b0;
            volt_vld_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            avg_vld_reg  <= avg_vld_next;
            volt_vld_reg <= volt_vld_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_avg_reg  <= p_avg_next;
        p_volt_reg <= p_volt_next;
        volts_reg  <= volts_next;
    end

    assign done  = done_reg;
    assign volts = volts_reg;

endmodule

`default_nettype wire

/* design/aidl_horner.sv */
// Sequential Horner evaluation of the sixth-order linearizing polynomial, with output saturation.
`default_nettype none

module aidl_horner (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [aidl_pkg::VOLT_W-1:0]        volts,
    output logic                               done,
    output logic signed [aidl_pkg::DIST_W-1:0] distance
);
    import aidl_pkg::*;

    localparam int LO_W = HALF_W + VOLT_W;
    localparam int D_W  = ACC_W - DIST_SH;

    localparam logic [2:0] H_IDLE = 3'd0;
    localparam logic [2:0] H_LO   = 3'd1;
    localparam logic [2:0] H_HI   = 3'd2;
    localparam logic [2:0] H_ADD  = 3'd3;
    localparam logic [2:0] H_SAT  = 3'd4;

    logic [2:0]                 state_reg, state_next;
    logic [COEF_IW-1:0]         idx_reg, idx_next;
    logic                       done_reg, done_next;
    logic signed [ACC_W-1:0]    acc_reg, acc_next;
    logic [VOLT_W-1:0]          volts_reg, volts_next;
    logic [LO_W-1:0]            p_lo_reg, p_lo_next;
    logic signed [ACC_W-1:0]    p_hi_reg, p_hi_next;
    logic signed [DIST_W-1:0]   dist_reg, dist_next;

    logic signed [HALF_W-1:0]   acc_hi;
    logic signed [HALF_W-1:0]   volts_s;
    logic signed [PROD_W-1:0]   prod;
    logic signed [D_W-1:0]      dist_full;

    assign acc_hi    = $signed(acc_reg[ACC_W-1:HALF_W]);
    assign volts_s   = $signed(HALF_W'(volts_reg));
    // recombine the two partial products
    assign prod      = (PROD_W'(p_hi_reg) <<< HALF_W) + $signed(PROD_W'(p_lo_reg));
    assign dist_full = $signed(acc_reg[ACC_W-1:DIST_SH]);

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        done_next  = 1'b0;
        acc_next   = acc_reg;
        volts_next = volts_reg;
        p_lo_next  = p_lo_reg;
        p_hi_next  = p_hi_reg;
        dist_next  = dist_reg;
        case (state_reg)
            H_IDLE:
            begin
                if (start)
                begin
                    volts_next = volts;
                    acc_next   = poly_coef(COEF_IW'(0));
                    idx_next   = COEF_IW'(1);
                    state_next = H_LO;
                end
            end
            H_LO:
            begin
                // low half of the accumulator, unsigned
                p_lo_next  = LO_W'(acc_reg[HALF_W-1:0]) * LO_W'(volts_reg);
                state_next = H_HI;
            end
            H_HI:
            begin
                // high half, signed
                p_hi_next  = ACC_W'(acc_hi) * ACC_W'(volts_s);
                state_next = H_ADD;
            end
            H_ADD:
            begin
                // floor(acc * v / 2^16) + c
                acc_next = $signed(prod[ACC_W+FRAC_W-1:FRAC_W]) + poly_coef(idx_reg);
                if (idx_reg == COEF_IW'(COEF_N - 1))
                begin
                    state_next = H_SAT;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = H_LO;
                end
            end
            H_SAT:
            begin
                if (dist_full > D_W'(DIST_MAX))
                begin
                    dist_next = DIST_MAX;
                end
                else if (dist_full < D_W'(DIST_MIN))
                begin
                    dist_next = DIST_MIN;
                end
                else
                begin
                    dist_next = dist_full[DIST_W-1:0];
                end
                done_next  = 1'b1;
                state_next = H_IDLE;
            end
            default:
            begin
                state_next = H_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= H_IDLE;
            idx_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg   <= acc_next;
        volts_reg <= volts_next;
        p_lo_reg  <= p_lo_next;
        p_hi_reg  <= p_hi_next;
        dist_reg  <= dist_next;
    end

    assign done     = done_reg;
    assign distance = dist_reg;

endmodule

`default_nettype wire

/* design/averaged_ir_distance_linearizer_core.sv */
// Top level of the averaged IR distance linearizer: sequencing, volt scaling and result register.
//
//  Channel      Dir  Payload                        Handshake
//  sample_ch    in   adc_sample  [9:0]  unsigned    valid/ready
//  distance_ch  out  distance    [19:0] signed Q12.8 valid/ready
//
// One request at a time. The first WINDOW requests only fill the window and give no result.
// After that a request passes, before the next can be taken, through the window memory
// read-modify-write, the average and volt scaling (two reciprocal multiplications and the
// clamp), the Horner unit (load, six steps of low product, high product and add,
// saturation) and the load of the output register.
// Reset clears control state only; the window memory is not cleared and is never read
// before it is written. A finished result waits in the output register while the next
// request is taken; the sequencer stalls only if a second result is ready before then.
`default_nettype none

module averaged_ir_distance_linearizer_core #(
    parameter int WINDOW         = aidl_pkg::WINDOW_DEF,
    parameter int ADC_FULL_SCALE = aidl_pkg::ADC_FULL_SCALE_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    aidl_sample_if.sink    sample_ch,
    aidl_distance_if.source distance_ch
);
    import aidl_pkg::*;

    localparam int TOTAL_W = $clog2(WINDOW * ((1 << SAMPLE_W) - 1) + 1);

    localparam logic [2:0] T_IDLE  = 3'd0;
    localparam logic [2:0] T_WIN   = 3'd1;
    localparam logic [2:0] T_SCALE = 3'd2;
    localparam logic [2:0] T_POLY  = 3'd3;
    localparam logic [2:0] T_HOLD  = 3'd4;

    logic [2:0]               state_reg, state_next;
    logic                     out_valid_reg, out_valid_next;
    logic signed [DIST_W-1:0] out_dist_reg, out_dist_next;

    logic                     accept;
    logic                     out_free;
    win_status_t              win_status;
    logic [TOTAL_W-1:0]       total;
    logic                     scale_start;
    logic                     scale_done;
    logic [VOLT_W-1:0]        volts;
    logic                     poly_start;
    logic                     poly_done;
    logic signed [DIST_W-1:0] poly_dist;

    assign accept          = sample_ch.valid & sample_ch.ready;
    assign sample_ch.ready = (state_reg == T_IDLE);
    assign out_free        = !out_valid_reg | distance_ch.ready;

    // Scaling starts once the total is updated, Horner once the volts are ready
    assign scale_start = (state_reg == T_WIN) & win_status.done & win_status.emit;
    assign poly_start  = (state_reg == T_SCALE) & scale_done;

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        out_dist_next  = out_dist_reg;
        if (distance_ch.valid & distance_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            T_IDLE:
            begin
                if (accept)
                begin
                    state_next = T_WIN;
                end
            end
            T_WIN:
            begin
                if (win_status.done)
                begin
                    state_next = win_status.emit ? T_SCALE : T_IDLE;
                end
            end
            T_SCALE:
            begin
                if (scale_done)
                begin
                    state_next = T_POLY;
                end
            end
            T_POLY, T_HOLD:
            begin
                if ((poly_done | (state_reg == T_HOLD)) & out_free)
                begin
                    out_valid_next = 1'b1;
                    out_dist_next  = poly_dist;
                    state_next     = T_IDLE;
                end
                else if (poly_done)
                begin
                    state_next = T_HOLD;
                end
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_dist_reg <= out_dist_next;
    end

    assign distance_ch.valid    = out_valid_reg;
    assign distance_ch.distance = out_dist_reg;

    aidl_window #(
        .WINDOW  (WINDOW),
        .TOTAL_W (TOTAL_W)
    ) u_window (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (accept),
        .sample (sample_ch.adc_sample),
        .status (win_status),
        .total  (total)
    );

    aidl_divider #(
        .WINDOW         (WINDOW),
        .ADC_FULL_SCALE (ADC_FULL_SCALE),
        .TOTAL_W        (TOTAL_W)
    ) u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .start (scale_start),
        .total (total),
        .done  (scale_done),
        .volts (volts)
    );

    aidl_horner u_horner (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (poly_start),
        .volts    (volts),
        .done     (poly_done),
        .distance (poly_dist)
    );

endmodule

`default_nettype wire

/* dv/averaged_ir_distance_linearizer_core_tb.sv */
// Testbench for the averaged IR distance linearizer: directed table, then random sample runs.
`timescale 1ns / 1ps

module averaged_ir_distance_linearizer_core_tb;

    import aidl_pkg::*;

    localparam int WIN         = WINDOW_DEF;
    localparam int FULL_SCALE  = ADC_FULL_SCALE_DEF;
    localparam int RANDOM_N    = 950;
    localparam int GAP_MAX     = 16;
    localparam int DRAIN_LIMIT = 20000;
    localparam int TAIL_CYCLES = 200;
    localparam int PRINT_CAP   = 50;

    // How a table row gets its expectation
    typedef enum logic [1:0] {
        ROW_PREDICT,    // worked out by the predictor
        ROW_NONE,       // window still filling, no distance
        ROW_VALUE       // value typed in below
    } row_kind_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0]        sample;
        row_kind_t                  kind;
        logic signed [DIST_W-1:0]   dist_val;
    } stim_row_t;

    localparam int DIR_N = 25;

    // Ten zeros fill the window; the eleventh gives the distance at 0 V.
    // Ten full-scale samples then push the average to its top, and the last
    // rows walk the bit patterns.
    stim_row_t directed_rows [DIR_N] = '{
        '{10'h000, ROW_NONE,    20'sd0}, '{10'h000, ROW_NONE,    20'sd0},
        '{10'h000, ROW_NONE,    20'sd0}, '{10'h000, ROW_NONE,    20'sd0},
        '{10'h000, ROW_NONE,    20'sd0}, '{10'h000, ROW_NONE,    20'sd0},
        '{10'h000, ROW_NONE,    20'sd0}, '{10'h000, ROW_NONE,    20'sd0},
        '{10'h000, ROW_NONE,    20'sd0}, '{10'h000, ROW_NONE,    20'sd0},
        '{10'h000, ROW_VALUE,   20'sd30904},
        '{10'h3FF, ROW_PREDICT, 20'sd0}, '{10'h3FF, ROW_PREDICT, 20'sd0},
        '{10'h3FF, ROW_PREDICT, 20'sd0}, '{10'h3FF, ROW_PREDICT, 20'sd0},
        '{10'h3FF, ROW_PREDICT, 20'sd0}, '{10'h3FF, ROW_PREDICT, 20'sd0},
        '{10'h3FF, ROW_PREDICT, 20'sd0}, '{10'h3FF, ROW_PREDICT, 20'sd0},
        '{10'h3FF, ROW_PREDICT, 20'sd0}, '{10'h3FF, ROW_PREDICT, 20'sd0},
        '{10'h155, ROW_PREDICT, 20'sd0}, '{10'h2AA, ROW_PREDICT, 20'sd0},
        '{10'h001, ROW_PREDICT, 20'sd0}, '{10'h200, ROW_PREDICT, 20'sd0}
    };

    // Q10.16 coefficients, highest power first
    longint horner_coef [COEF_N] = '{
        64'sd81933, -64'sd1074528, 64'sd5569446, -64'sd14775747,
        64'sd21679309, -64'sd17832346, 64'sd7911506
    };

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    aidl_sample_if   sample_ch ();
    aidl_distance_if distance_ch ();

    averaged_ir_distance_linearizer_core #(
        .WINDOW         (WIN),
        .ADC_FULL_SCALE (FULL_SCALE)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .sample_ch   (sample_ch),
        .distance_ch (distance_ch)
    );

    // Predictor state: sample window and running sum
    logic [SAMPLE_W-1:0]      win_hist [WIN];
    int                       hist_slot;
    int                       hist_total;
    int                       hist_fill;

    logic signed [DIST_W-1:0] expected_dist [$];
    int                       mismatches;
    bit                       src_no_idle;
    bit                       sink_no_idle;
    int                       sink_runs;

    initial
    begin
        forever #10 clk = ~clk;
    end

    task automatic report_mismatch(input string what);
        if (mismatches < PRINT_CAP)
            $display("[%0t] MISMATCH: %s", $time, what);
        mismatches++;
    endtask

    // Window average -> volts (Q3.16) -> Horner polynomial -> Q12.8 distance
    function automatic logic signed [DIST_W-1:0] distance_for_total(input int total);
        longint avg;
        longint volts;
        longint acc;
        longint d;
        avg   = total / WIN;
        volts = (avg * 5 * 65536) / FULL_SCALE;
        if (volts > longint'(VOLT_MAX))
            volts = longint'(VOLT_MAX);
        acc = horner_coef[0];
        for (int k = 1; k < COEF_N; k++)
            acc = ((acc * volts) >>> FRAC_W) + horner_coef[k];
        d = acc >>> DIST_SH;
        if (d > longint'(DIST_MAX))
            d = longint'(DIST_MAX);
        if (d < longint'(DIST_MIN))
            d = longint'(DIST_MIN);
        return d[DIST_W-1:0];
    endfunction

    // Fold one accepted request into the predictor state
    task automatic predict_sample(input logic [SAMPLE_W-1:0] s, output bit gives,
                                  output logic signed [DIST_W-1:0] dist_val);
        gives    = 1'b0;
        dist_val = '0;
        if (hist_fill < WIN)
        begin
            win_hist[hist_fill] = s;
            hist_total += int'(s);
            hist_fill++;
        end
        else
        begin
            hist_total -= int'(win_hist[hist_slot]);
            win_hist[hist_slot] = s;
            hist_total += int'(s);
            hist_slot = (hist_slot + 1 == WIN) ? 0 : hist_slot + 1;
            gives    = 1'b1;
            dist_val = distance_for_total(hist_total);
        end
    endtask

    // Offer one request after a random gap; valid stays high on return
    task automatic send_sample(input logic [SAMPLE_W-1:0] s, input row_kind_t kind,
                               input logic signed [DIST_W-1:0] typed);
        int                       gap;
        bit                       gives;
        logic signed [DIST_W-1:0] dist_val;
        gap = src_no_idle ? 0 : int'($urandom_range(0, GAP_MAX));
        if (gap != 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_ch.valid      <= 1'b1;
        sample_ch.adc_sample <= s;
        do @(posedge clk); while (!(sample_ch.valid && sample_ch.ready));
        predict_sample(s, gives, dist_val);
        case (kind)
            ROW_PREDICT: if (gives) expected_dist.push_back(dist_val);
            ROW_VALUE:   expected_dist.push_back(typed);
            default:     ;
        endcase
    endtask

    // Hold off new requests until every distance due has come back
    task automatic pause_until_drained();
        sample_ch.valid <= 1'b0;
        do @(posedge clk); while (expected_dist.size() != 0);
    endtask

    // One sample of a run around a level, clipped to the converter range
    function automatic logic [SAMPLE_W-1:0] run_sample(input int level, input int spread);
        int v;
        v = level + int'($urandom_range(0, 2 * spread)) - spread;
        if (v < 0)
            v = 0;
        if (v > 1023)
            v = 1023;
        return v[SAMPLE_W-1:0];
    endfunction

    // Result side: random stalls on ready
    initial
    begin : result_sink
        int stall;
        distance_ch.ready <= 1'b0;
        sink_runs = 0;
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (sink_runs == 0)
            begin
                sink_no_idle = ($urandom_range(0, 3) == 0);
                sink_runs    = $urandom_range(10, 40);
            end
            sink_runs--;
            stall = sink_no_idle ? 0 : int'($urandom_range(0, GAP_MAX));
            if (stall != 0)
            begin
                distance_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            distance_ch.ready <= 1'b1;
            do @(posedge clk); while (!(distance_ch.valid && distance_ch.ready));
        end
    end

    // Compare each accepted distance with the oldest expectation
    always @(posedge clk)
    begin : check_distance
        logic signed [DIST_W-1:0] want;
        if (rst_n && distance_ch.valid && distance_ch.ready)
        begin
            if (expected_dist.size() == 0)
                report_mismatch($sformatf("distance %0d with no request waiting",
                                          distance_ch.distance));
            else
            begin
                want = expected_dist.pop_front();
                if (distance_ch.distance !== want)
                    report_mismatch($sformatf("distance got %0d want %0d",
                                              distance_ch.distance, want));
            end
        end
    end

    // Stimulus
    initial
    begin : stimulus
        int sent;
        int run_len;
        int level;
        int spread;
        int drain_cycles;
        sample_ch.valid      <= 1'b0;
        sample_ch.adc_sample <= '0;
        mismatches  = 0;
        hist_slot   = 0;
        hist_total  = 0;
        hist_fill   = 0;
        src_no_idle = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table
        for (int i = 0; i < DIR_N; i++)
        begin
            src_no_idle = ($urandom_range(0, 2) == 0);
            send_sample(directed_rows[i].sample, directed_rows[i].kind,
                        directed_rows[i].dist_val);
        end

        // Random runs: a level held for a while, with noise of varying width
        sent = 0;
        while (sent < RANDOM_N)
        begin
            src_no_idle = ($urandom_range(0, 3) == 0);
            run_len     = $urandom_range(5, 40);
            if ($urandom_range(0, 5) == 0)
                level = $urandom_range(0, 1) ? 1023 : 0;
            else
                level = $urandom_range(0, 1023);
            case ($urandom_range(0, 3))
                0:       spread = 0;
                1:       spread = 4;
                2:       spread = 64;
                default: spread = 1023;
            endcase
            for (int j = 0; j < run_len && sent < RANDOM_N; j++)
            begin
                send_sample(run_sample(level, spread), ROW_PREDICT, '0);
                sent++;
                if (sent == 300 || sent == 700)
                    pause_until_drained();
            end
        end

        // Drain, then watch for stray distances
        sample_ch.valid <= 1'b0;
        drain_cycles = 0;
        while (expected_dist.size() != 0 && drain_cycles < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain_cycles++;
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_dist.size() != 0)
            report_mismatch($sformatf("%0d distances never arrived", expected_dist.size()));

        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog
    initial
    begin
        #15000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
